// ----- hdl/sgrt_pkg.sv -----
package sgrt_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned SEQ_W  = 31;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  localparam logic REQ_FULL = 1'b0;
  localparam logic REQ_ONE  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PKT = 2'd0,
    KIND_END = 2'd1,
    KIND_ERR = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_IN_ORDER  = 3'd0,
    ST_GAP       = 3'd1,
    ST_OLD       = 3'd2,
    ST_RECOVERED = 3'd3,
    ST_WRONG     = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_EVENT     = 3'd6
  } status_e;

  // One queued missing range [start_seq, stop_seq).
  typedef struct packed {
    logic [SEQ_W-1:0] start_seq;
    logic [SEQ_W-1:0] stop_seq;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    status_e          status;
    logic             request_valid;
    logic             request_type;
    logic [SEQ_W-1:0] request_seq;
    logic [SEQ_W-1:0] gap_start;
    logic [SEQ_W-1:0] gap_end;
    logic             done_res;
  } res_t;

endpackage

// ----- hdl/sgrt_in_if.sv -----
interface sgrt_in_if;
  import sgrt_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SEQ_W-1:0]  seq;

  modport source (output valid, kind, seq, input ready);
  modport sink   (input valid, kind, seq, output ready);
endinterface

// ----- hdl/sgrt_out_if.sv -----
interface sgrt_out_if;
  import sgrt_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              request_valid;
  logic              request_type;
  logic [SEQ_W-1:0]  request_seq;
  logic [SEQ_W-1:0]  gap_start;
  logic [SEQ_W-1:0]  gap_end;
  logic              done_res;

  modport source (output valid, status, request_valid, request_type, request_seq,
                  gap_start, gap_end, done_res, input ready);
  modport sink   (input valid, status, request_valid, request_type, request_seq,
                  gap_start, gap_end, done_res, output ready);
endinterface

// ----- hdl/sequence_gap_recovery_tracker.sv -----
// Sequence gap tracker with retransmit requests. Every input word carries a kind (packet,
// end of stream, link error) and a sequence number, and produces exactly one result word.
// While streaming, a packet that jumps past the last number plus one queues the missing
// range, or reports overflow if the queue is full; older or duplicate numbers queue nothing.
// At end of stream an empty queue reports done, otherwise the block switches to recovery and
// asks for the head range one number at a time. A link error drops the queue and asks for
// the full stream, unless recovery has already drained it, in which case done is reported.
// Done is sticky until reset. The block takes one word per clock cycle while the result
// buffer has room; each result is registered. The rate is set by the single compare-and-update
// of the head cell of the range queue, which is a row of 16 cells that shift toward the head
// on a pop. A two-word result buffer lets the input keep accepting while one result waits at
// the output; the input stalls only when both words are full.
module sequence_gap_recovery_tracker (
  input  logic         clk_i,
  input  logic         rst_ni,
  sgrt_in_if.sink      in_i,
  sgrt_out_if.source   out_o
);
  import sgrt_pkg::*;

  logic [SEQ_W-1:0] last_q, last_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             rec_q, rec_d;
  logic             bl_q, bl_d;
  logic             fin_q, fin_d;

  entry_t cells [DEPTH];
  entry_t load_ent;
  logic   push, pop, head_ld;
  logic   go, buf_ready;
  res_t   res, res_out;

  logic [SEQ_W:0]   next_seq;
  logic [SEQ_W:0]   in_seq;
  logic [SEQ_W-1:0] head_nxt;

  assign go       = in_i.valid && buf_ready;
  assign in_i.ready = buf_ready;
  assign next_seq = {1'b0, last_q} + {{SEQ_W{1'b0}}, 1'b1};
  assign in_seq   = {1'b0, in_i.seq};
  assign head_nxt = cells[0].start_seq + {{(SEQ_W-1){1'b0}}, 1'b1};

  // The next-state and result logic works on one word. Nothing is committed unless the
  // word is accepted this cycle.
  always_comb begin
    res      = '0;
    last_d   = last_q;
    cnt_d    = cnt_q;
    rec_d    = rec_q;
    bl_d     = bl_q;
    fin_d    = fin_q;
    push     = 1'b0;
    pop      = 1'b0;
    head_ld  = 1'b0;
    load_ent = '{start_seq: next_seq[SEQ_W-1:0], stop_seq: in_i.seq};

    if (fin_q) begin
      res.status   = ST_EVENT;
      res.done_res = 1'b1;
    end else begin
      case (kind_e'(in_i.kind))
        KIND_PKT: begin
          if (!rec_q) begin
            // Streaming: compare against the last number plus one.
            if (in_seq == next_seq) begin
              res.status = ST_IN_ORDER;
            end else if (in_seq > next_seq) begin
              if (cnt_q == CNT_W'(DEPTH)) begin
                res.status = ST_OVERFLOW;
              end else begin
                push          = 1'b1;
                cnt_d         = cnt_q + {{(CNT_W-1){1'b0}}, 1'b1};
                res.status    = ST_GAP;
                res.gap_start = next_seq[SEQ_W-1:0];
                res.gap_end   = in_i.seq;
              end
            end else begin
              res.status = ST_OLD;
            end
            last_d = in_i.seq;
          end else if (cnt_q == '0) begin
            fin_d        = 1'b1;
            res.status   = ST_RECOVERED;
            res.done_res = 1'b1;
          end else if (in_i.seq != cells[0].start_seq) begin
            // Wrong packet during recovery: ask for the same number again.
            res.status        = ST_WRONG;
            res.request_valid = 1'b1;
            res.request_type  = REQ_ONE;
            res.request_seq   = cells[0].start_seq;
          end else begin
            res.status = ST_RECOVERED;
            if (head_nxt >= cells[0].stop_seq) begin
              // Head range exhausted: every cell hands its range one place forward.
              pop   = 1'b1;
              cnt_d = cnt_q - {{(CNT_W-1){1'b0}}, 1'b1};
              if (cnt_q == {{(CNT_W-1){1'b0}}, 1'b1}) begin
                fin_d        = 1'b1;
                res.done_res = 1'b1;
              end else begin
                res.request_valid = 1'b1;
                res.request_type  = REQ_ONE;
                res.request_seq   = cells[1].start_seq;
              end
            end else begin
              head_ld           = 1'b1;
              load_ent          = '{start_seq: head_nxt, stop_seq: cells[0].stop_seq};
              res.request_valid = 1'b1;
              res.request_type  = REQ_ONE;
              res.request_seq   = head_nxt;
            end
          end
        end
        KIND_END: begin
          res.status = ST_EVENT;
          if (cnt_q == '0) begin
            fin_d        = 1'b1;
            res.done_res = 1'b1;
          end else begin
            rec_d             = 1'b1;
            bl_d              = 1'b1;
            res.request_valid = 1'b1;
            res.request_type  = REQ_ONE;
            res.request_seq   = cells[0].start_seq;
          end
        end
        KIND_ERR: begin
          res.status = ST_EVENT;
          if (bl_q && cnt_q == '0) begin
            fin_d        = 1'b1;
            res.done_res = 1'b1;
          end else begin
            cnt_d             = '0;
            rec_d             = 1'b0;
            res.request_valid = 1'b1;
            res.request_type  = REQ_FULL;
          end
        end
        default: begin
          res.status = ST_EVENT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      cnt_q  <= '0;
      rec_q  <= 1'b0;
      bl_q   <= 1'b0;
      fin_q  <= 1'b0;
    end else if (go) begin
      last_q <= last_d;
      cnt_q  <= cnt_d;
      rec_q  <= rec_d;
      bl_q   <= bl_d;
      fin_q  <= fin_d;
    end
  end

  // Range queue: cell zero is always the head. A push writes the first free cell, a pop
  // shifts the whole row by one, and a partial recovery rewrites the head cell in place.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    nbr;

    assign ctl.shift = go && pop;
    assign ctl.load  = go && ((push && cnt_q == CNT_W'(k)) || (head_ld && k == 0));

    if (k == DEPTH - 1) begin : g_tail
      assign nbr = cells[k];
    end else begin : g_body
      assign nbr = cells[k+1];
    end

    sgrt_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .load_i  (load_ent),
      .next_i  (nbr),
      .entry_o (cells[k])
    );
  end

  sgrt_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (go),
    .res_i   (res),
    .ready_o (buf_ready),
    .valid_o (out_o.valid),
    .pop_i   (out_o.ready),
    .res_o   (res_out)
  );

  assign out_o.status        = res_out.status;
  assign out_o.request_valid = res_out.request_valid;
  assign out_o.request_type  = res_out.request_type;
  assign out_o.request_seq   = res_out.request_seq;
  assign out_o.gap_start     = res_out.gap_start;
  assign out_o.gap_end       = res_out.gap_end;
  assign out_o.done_res      = res_out.done_res;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("range queue count beyond depth");

  a_fin_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> fin_q)
    else $error("done flag cleared without reset");

  a_rec_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_q && !fin_q) |-> (cnt_q != '0))
    else $error("recovery mode with an empty range queue");
`endif

endmodule

// ----- hdl/sgrt_cell.sv -----
module sgrt_cell (
  input  logic                clk_i,
  input  sgrt_pkg::cell_ctl_t ctl_i,
  input  sgrt_pkg::entry_t    load_i,
  input  sgrt_pkg::entry_t    next_i,
  output sgrt_pkg::entry_t    entry_o
);
  import sgrt_pkg::*;

  entry_t entry_q, entry_d;

  // A load has priority; a shift pulls the neighbor's range one place toward the head.
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.load) begin
      entry_d = load_i;
    end else if (ctl_i.shift) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- hdl/sgrt_obuf.sv -----
module sgrt_obuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sgrt_pkg::res_t res_i,
  output logic           ready_o,
  output logic           valid_o,
  input  logic           pop_i,
  output sgrt_pkg::res_t res_o
);
  import sgrt_pkg::*;

  logic main_v_q, skid_v_q;
  res_t main_q, skid_q;
  logic take;

  assign ready_o = !skid_v_q;
  assign valid_o = main_v_q;
  assign res_o   = main_q;
  assign take    = main_v_q && pop_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!main_v_q || take) begin
        if (skid_v_q) begin
          main_v_q <= 1'b1;
          skid_v_q <= 1'b0;
        end else begin
          main_v_q <= push_i;
        end
      end else if (push_i) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_v_q || take) begin
      main_q <= skid_v_q ? skid_q : res_i;
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid word held while main word is empty");
`endif

endmodule
